// ===== hdl/pnm_pkg.sv =====
// Package with the shared types and constants of the min-max normalizer.
package pnm_pkg;

	localparam int unsigned MAX_CH = 4;
	localparam logic [16:0] ONE_Q16 = 17'h10000;
	localparam logic signed [31:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] SAMPLE_MIN = 32'sh8000_0000;

	localparam logic [1:0] MODE_LUMA = 2'd0;
	localparam logic [1:0] MODE_RGB = 2'd1;
	localparam logic [1:0] MODE_RGBA = 2'd2;
	localparam logic [1:0] MODE_SPARE = 2'd3;

	localparam logic KIND_GATHER = 1'b0;
	localparam logic KIND_NORM = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic gather;
		logic freeze;
		logic start;
		logic step;
	} lane_ctrl_t;

endpackage

// ===== hdl/pnm_if.sv =====
// Interfaces for the pixel input, result output and configuration channels.
interface pnm_pix_in_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic signed [31:0] in_ch0;
	logic signed [31:0] in_ch1;
	logic signed [31:0] in_ch2;
	logic signed [31:0] in_ch3;
	logic               last_pixel;

	modport source (output valid, kind, in_ch0, in_ch1, in_ch2, in_ch3, last_pixel,
		input ready);
	modport sink (input valid, kind, in_ch0, in_ch1, in_ch2, in_ch3, last_pixel,
		output ready);
endinterface

interface pnm_pix_out_if;
	logic        valid;
	logic        ready;
	logic [16:0] out_ch0;
	logic [16:0] out_ch1;
	logic [16:0] out_ch2;
	logic [16:0] out_ch3;
	logic        out_last;

	modport source (output valid, out_ch0, out_ch1, out_ch2, out_ch3, out_last,
		input ready);
	modport sink (input valid, out_ch0, out_ch1, out_ch2, out_ch3, out_last,
		output ready);
endinterface

interface pnm_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] channel_mode;

	modport source (output valid, channel_mode, input ready);
	modport sink (input valid, channel_mode, output ready);
endinterface

// ===== hdl/per_channel_minmax_normalize_core.sv =====
// Top level: pixel handshake, lane control, result merge and output register.
// A gather word is taken and gives no result.
// A normalize word's result passes through 16 steps of each lane's restoring divider
// and one merge into the output register, which waits while the output is stalled.
// No word is taken until a normalize result is merged; gather words run one per cycle.
// arst_n clears statistics to their empty values, frozen ranges to 1.0 and mode to RGBA.
module per_channel_minmax_normalize_core #(
	parameter int LANES = 4
) (
	input  logic clk,
	input  logic arst_n,
	pnm_pix_in_if.sink    pix_in,
	pnm_pix_out_if.source pix_out,
	pnm_cfg_if.sink       cfg
);

	// Channel count register, taken whenever a configuration word arrives.
	logic [1:0] mode_q;

	pnm_pkg::state_t state_q;
	pnm_pkg::state_t state_nx;
	logic [3:0] cnt_q;
	logic       last_q;

	logic        out_valid_q;
	logic [16:0] out_q [pnm_pkg::MAX_CH];
	logic        out_last_q;

	logic        in_acc;
	logic        out_load;
	logic        div_end;
	logic [2:0]  n_act;
	pnm_pkg::lane_ctrl_t ctrl;
	logic signed [31:0] samples [pnm_pkg::MAX_CH];
	logic [16:0] res [pnm_pkg::MAX_CH];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= pnm_pkg::MODE_RGBA;
		end else if (cfg.valid) begin
			mode_q <= cfg.channel_mode;
		end
	end

	// Luminance uses lane 0, RGB lanes 0 to 2, and both RGBA and the spare code use four.
	always_comb begin
		unique case (mode_q)
			pnm_pkg::MODE_LUMA: n_act = 3'd1;
			pnm_pkg::MODE_RGB:  n_act = 3'd3;
			default:            n_act = 3'd4;
		endcase
	end

	assign samples[0] = pix_in.in_ch0;
	assign samples[1] = pix_in.in_ch1;
	assign samples[2] = pix_in.in_ch2;
	assign samples[3] = pix_in.in_ch3;

	assign in_acc = pix_in.valid && pix_in.ready;
	assign div_end = (state_q == pnm_pkg::ST_DIV) && (cnt_q == 4'd15);
	assign out_load = (state_q == pnm_pkg::ST_DONE) && (!out_valid_q || pix_out.ready);

	// Next state.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			pnm_pkg::ST_IDLE: begin
				if (in_acc && (pix_in.kind == pnm_pkg::KIND_NORM)) begin
					state_nx = pnm_pkg::ST_DIV;
				end
			end
			pnm_pkg::ST_DIV: begin
				if (div_end) begin
					state_nx = pnm_pkg::ST_DONE;
				end
			end
			pnm_pkg::ST_DONE: begin
				if (out_load) begin
					state_nx = pnm_pkg::ST_IDLE;
				end
			end
			default: state_nx = pnm_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the state machine: input handshake and the lane controls.
	always_comb begin
		pix_in.ready = (state_q == pnm_pkg::ST_IDLE);
		ctrl.gather = in_acc && (pix_in.kind == pnm_pkg::KIND_GATHER);
		ctrl.freeze = in_acc && (pix_in.kind == pnm_pkg::KIND_GATHER) && pix_in.last_pixel;
		ctrl.start = in_acc && (pix_in.kind == pnm_pkg::KIND_NORM);
		ctrl.step = (state_q == pnm_pkg::ST_DIV);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pnm_pkg::ST_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (ctrl.start) begin
				cnt_q <= '0;
			end else if (ctrl.step) begin
				cnt_q <= cnt_q + 4'd1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pix_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			last_q <= pix_in.last_pixel;
		end
		if (out_load) begin
			out_last_q <= last_q;
			for (int i = 0; i < pnm_pkg::MAX_CH; i++) begin
				out_q[i] <= res[i];
			end
		end
	end

	// The lanes work side by side; lanes beyond LANES give a zero field.
	for (genvar g = 0; g < pnm_pkg::MAX_CH; g++) begin : g_lane
		if (g < LANES) begin : g_on
			pnm_lane u_lane (
				.clk    (clk),
				.arst_n (arst_n),
				.ctrl   (ctrl),
				.active (3'(g) < n_act),
				.sample (samples[g]),
				.result (res[g])
			);
		end else begin : g_off
			assign res[g] = '0;
		end
	end

	assign pix_out.valid = out_valid_q;
	assign pix_out.out_ch0 = out_q[0];
	assign pix_out.out_ch1 = out_q[1];
	assign pix_out.out_ch2 = out_q[2];
	assign pix_out.out_ch3 = out_q[3];
	assign pix_out.out_last = out_last_q;

endmodule

// ===== hdl/pnm_lane.sv =====
// One channel lane: running statistics, frozen range and a bit-serial divider.
module pnm_lane (
	input  logic                clk,
	input  logic                arst_n,
	input  pnm_pkg::lane_ctrl_t ctrl,
	input  logic                active,
	input  logic signed [31:0]  sample,
	output logic [16:0]         result
);

	logic signed [31:0] run_min_q;
	logic signed [31:0] run_max_q;
	logic signed [31:0] frz_min_q;
	logic [32:0]        frz_range_q;
	logic [32:0]        rem_q;
	logic [15:0]        quo_q;
	logic               zero_q;
	logic               sat_q;

	logic signed [31:0] min_nx;
	logic signed [31:0] max_nx;
	logic signed [32:0] span;
	logic               span_bad;
	logic signed [32:0] diff;
	logic               diff_bad;
	logic [33:0]        rem_sh;
	logic [33:0]        range_w;
	logic               ge;

	always_comb begin
		min_nx = run_min_q;
		max_nx = run_max_q;
		if (ctrl.gather && active) begin
			if (sample < run_min_q) begin
				min_nx = sample;
			end
			if (sample > run_max_q) begin
				max_nx = sample;
			end
		end
		span = {max_nx[31], max_nx} - {min_nx[31], min_nx};
		span_bad = span[32] || (span == 33'sd0);
		diff = {sample[31], sample} - {frz_min_q[31], frz_min_q};
		diff_bad = diff[32] || (diff == 33'sd0);
		range_w = {1'b0, frz_range_q};
		rem_sh = {rem_q, 1'b0};
		ge = (rem_sh >= range_w);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_min_q <= pnm_pkg::SAMPLE_MAX;
			run_max_q <= pnm_pkg::SAMPLE_MIN;
			frz_min_q <= '0;
			frz_range_q <= {16'd0, pnm_pkg::ONE_Q16};
		end else if (ctrl.freeze) begin
			// The last gather pixel is already folded into min_nx and max_nx.
			if (span_bad) begin
				frz_min_q <= '0;
				frz_range_q <= {16'd0, pnm_pkg::ONE_Q16};
			end else begin
				frz_min_q <= min_nx;
				frz_range_q <= $unsigned(span);
			end
			run_min_q <= pnm_pkg::SAMPLE_MAX;
			run_max_q <= pnm_pkg::SAMPLE_MIN;
		end else if (ctrl.gather) begin
			run_min_q <= min_nx;
			run_max_q <= max_nx;
		end
	end

	// Unless the word saturates or gives zero, the partial remainder stays below the range, so it fits in 33 bits.
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			zero_q <= diff_bad;
			sat_q <= !diff_bad && ($unsigned(diff) >= frz_range_q);
			rem_q <= $unsigned(diff);
			quo_q <= '0;
		end else if (ctrl.step) begin
			rem_q <= ge ? 33'(rem_sh - range_w) : rem_sh[32:0];
			quo_q <= {quo_q[14:0], ge};
		end
	end

	always_comb begin
		if (!active || zero_q) begin
			result = '0;
		end else if (sat_q) begin
			result = pnm_pkg::ONE_Q16;
		end else begin
			result = {1'b0, quo_q};
		end
	end

endmodule

// ===== sim/pnm_tb_if.sv =====
// Scoreboard package of the min-max normalizer testbench.
`timescale 1ns / 100ps
package pnm_tb_pkg;

	typedef struct {
		logic [16:0] ch [4];
		logic        last;
	} norm_word_t;

	class norm_scoreboard;
		logic [1:0]         mode;
		logic signed [31:0] run_min [4];
		logic signed [31:0] run_max [4];
		logic signed [31:0] frz_min [4];
		logic signed [33:0] frz_rng [4];
		norm_word_t         pending [$];
		int                 mismatches;

		function new();
			mode = pnm_pkg::MODE_RGBA;
			for (int i = 0; i < 4; i++) begin
				run_min[i] = pnm_pkg::SAMPLE_MAX;
				run_max[i] = pnm_pkg::SAMPLE_MIN;
				frz_min[i] = '0;
				frz_rng[i] = 34'sd65536;
			end
			mismatches = 0;
		endfunction

		function int lanes_on();
			return (mode == pnm_pkg::MODE_LUMA) ? 1 : (mode == pnm_pkg::MODE_RGB) ? 3 : 4;
		endfunction

		function logic [16:0] scale(logic signed [31:0] x, int i);
			logic signed [33:0] d;
			logic [63:0] q;
			d = 34'(x) - 34'(frz_min[i]);
			if (d <= 0 || frz_rng[i] <= 0) return '0;
			q = (64'(d) << 16) / 64'(frz_rng[i]);
			if (q > 64'd65536) q = 64'd65536;
			return q[16:0];
		endfunction

		// Notes one accepted pixel word; a normalize word queues its expected result.
		function void note_pixel(logic kind, logic signed [31:0] s [4], logic last);
			norm_word_t w;
			logic signed [33:0] r;
			int n;
			n = lanes_on();
			if (kind == pnm_pkg::KIND_GATHER) begin
				for (int i = 0; i < n; i++) begin
					if (s[i] < run_min[i]) run_min[i] = s[i];
					if (s[i] > run_max[i]) run_max[i] = s[i];
				end
				if (last) begin
					for (int i = 0; i < 4; i++) begin
						r = 34'(run_max[i]) - 34'(run_min[i]);
						if (r <= 0) begin
							frz_min[i] = '0;
							frz_rng[i] = 34'sd65536;
						end else begin
							frz_min[i] = run_min[i];
							frz_rng[i] = r;
						end
						run_min[i] = pnm_pkg::SAMPLE_MAX;
						run_max[i] = pnm_pkg::SAMPLE_MIN;
					end
				end
				return;
			end
			for (int i = 0; i < 4; i++) w.ch[i] = (i < n) ? scale(s[i], i) : '0;
			w.last = last;
			pending.push_back(w);
		endfunction

		function void check_result(logic [16:0] got [4], logic last);
			norm_word_t w;
			logic bad;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word");
				return;
			end
			w = pending.pop_front();
			bad = (last !== w.last);
			for (int i = 0; i < 4; i++) if (got[i] !== w.ch[i]) bad = 1'b1;
			if (bad) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp %h %h %h %h l%b got %h %h %h %h l%b",
						w.ch[0], w.ch[1], w.ch[2], w.ch[3], w.last,
						got[0], got[1], got[2], got[3], last);
			end
		endfunction
	endclass
endpackage

// ===== sim/tb_top.sv =====
// Top testbench of the min-max normalizer: random and directed pixels checked against a model.
`timescale 1ns / 100ps
module tb_top;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	pnm_pix_in_if  pin ();
	pnm_pix_out_if pout ();
	pnm_cfg_if     cfg ();

	per_channel_minmax_normalize_core #(.LANES(4)) uut (
		.clk(clk), .arst_n(arst_n), .pix_in(pin.sink), .pix_out(pout.source), .cfg(cfg.sink)
	);

	always #4 clk = ~clk;

	pnm_tb_pkg::norm_scoreboard sb = new();
	// While set, the result side holds ready low so the block fills and stalls its input.
	logic hold_off = 1'b0;
	logic drive_done = 1'b0;

	initial begin
		pin.valid = 1'b0; pin.kind = pnm_pkg::KIND_GATHER; pin.last_pixel = 1'b0;
		pin.in_ch0 = '0; pin.in_ch1 = '0; pin.in_ch2 = '0; pin.in_ch3 = '0;
		cfg.valid = 1'b0; cfg.channel_mode = pnm_pkg::MODE_RGBA;
		pout.ready = 1'b0;
	end

	// Sends one pixel word after the given gap, holding it until the block takes it.
	task automatic send_pixel(logic kind, logic signed [31:0] s [4], logic last, int gap);
		repeat (gap) @(negedge clk);
		pin.valid = 1'b1; pin.kind = kind; pin.last_pixel = last;
		pin.in_ch0 = s[0]; pin.in_ch1 = s[1]; pin.in_ch2 = s[2]; pin.in_ch3 = s[3];
		do @(posedge clk); while (!pin.ready);
		sb.note_pixel(kind, s, last);
		@(negedge clk);
		pin.valid = 1'b0;
	endtask

	// Waits until every expected result has come, then lets the divider drain.
	task automatic drain();
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	task automatic write_mode(logic [1:0] m);
		drain();
		cfg.valid = 1'b1; cfg.channel_mode = m;
		do @(posedge clk); while (!cfg.ready);
		sb.mode = m;
		@(negedge clk);
		cfg.valid = 1'b0;
	endtask

	// Samples are mostly small values around zero, sometimes full-range random values or extremes.
	function automatic logic signed [31:0] rand_sample();
		case ($urandom_range(0, 9))
			0: return pnm_pkg::SAMPLE_MAX;
			1: return pnm_pkg::SAMPLE_MIN;
			2, 3: return $urandom();
			default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
		endcase
	endfunction

	task automatic rand_pixel(logic kind, logic last, logic busy);
		logic signed [31:0] s [4];
		for (int i = 0; i < 4; i++) s[i] = rand_sample();
		send_pixel(kind, s, last, busy ? 0 : $urandom_range(0, 19));
	endtask

	// One region: a gather pass then a normalize pass, each ended by a last pixel.
	task automatic region(int gathers, int norms, logic busy);
		for (int i = 0; i < gathers; i++)
			rand_pixel(pnm_pkg::KIND_GATHER, i == gathers - 1, busy);
		for (int i = 0; i < norms; i++)
			rand_pixel(pnm_pkg::KIND_NORM, i == norms - 1, busy);
	endtask

	// Result side: a random wait before each word, and one long hold-off.
	initial begin
		logic [16:0] got [4];
		int gap;
		gap = $urandom_range(0, 19);
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) pout.ready = 1'b0;
			else if (gap > 0) begin
				pout.ready = 1'b0;
				gap--;
			end else begin
				pout.ready = 1'b1;
			end
			@(posedge clk);
			if (pout.valid && pout.ready) begin
				got[0] = pout.out_ch0; got[1] = pout.out_ch1;
				got[2] = pout.out_ch2; got[3] = pout.out_ch3;
				sb.check_result(got, pout.out_last);
				gap = $urandom_range(0, 19);
			end
		end
	end

	// Stimulus.
	initial begin
		logic signed [31:0] s [4];
		logic [1:0] m;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Normalize without any gather uses min 0 and range 1.0.
		s = '{32'sh0000_8000, pnm_pkg::SAMPLE_MAX, pnm_pkg::SAMPLE_MIN, 32'sd0};
		send_pixel(pnm_pkg::KIND_NORM, s, 1'b1, 0);
		// Extremes gathered, then normalized; full range in every lane.
		s = '{pnm_pkg::SAMPLE_MIN, pnm_pkg::SAMPLE_MAX, pnm_pkg::SAMPLE_MIN, pnm_pkg::SAMPLE_MAX};
		send_pixel(pnm_pkg::KIND_GATHER, s, 1'b0, 1);
		s = '{pnm_pkg::SAMPLE_MAX, pnm_pkg::SAMPLE_MIN, pnm_pkg::SAMPLE_MAX, pnm_pkg::SAMPLE_MIN};
		send_pixel(pnm_pkg::KIND_GATHER, s, 1'b1, 0);
		s = '{32'sd0, pnm_pkg::SAMPLE_MAX, pnm_pkg::SAMPLE_MIN, 32'sh4000_0000};
		send_pixel(pnm_pkg::KIND_NORM, s, 1'b0, 0);
		send_pixel(pnm_pkg::KIND_NORM, s, 1'b1, 2);
		// Flat channel: the same value twice gives min 0, range 1.0.
		s = '{32'sd70000, 32'sd70000, -32'sd5, 32'sd1};
		send_pixel(pnm_pkg::KIND_GATHER, s, 1'b0, 0);
		send_pixel(pnm_pkg::KIND_GATHER, s, 1'b1, 0);
		send_pixel(pnm_pkg::KIND_NORM, s, 1'b1, 0);
		// Empty region: a lone last gather on one active lane freezes the rest too.
		write_mode(pnm_pkg::MODE_LUMA);
		s = '{32'sd100, 32'sd200, 32'sd300, 32'sd400};
		send_pixel(pnm_pkg::KIND_GATHER, s, 1'b1, 0);
		s = '{32'sd150, 32'sd65536, 32'sd0, -32'sd1};
		send_pixel(pnm_pkg::KIND_NORM, s, 1'b1, 0);
		write_mode(pnm_pkg::MODE_RGB);
		region(3, 3, 1'b0);
		// The spare mode code acts as four channels.
		write_mode(pnm_pkg::MODE_SPARE);
		region(3, 3, 1'b0);

		// Back-pressure: hold results while the sender keeps offering normalize words.
		write_mode(pnm_pkg::MODE_RGBA);
		hold_off = 1'b1;
		fork
			begin
				repeat (400) @(negedge clk);
				hold_off = 1'b0;
			end
			region(2, 12, 1'b1);
		join
		drain();

		// Random regions across all modes.
		for (int n = 0; n < 190; n++) begin
			if (n % 15 == 0) begin
				m = 2'($urandom_range(0, 3));
				write_mode(m);
			end
			region($urandom_range(1, 10), $urandom_range(1, 8), $urandom_range(0, 3) == 0);
			if ($urandom_range(0, 7) == 0) drain();
			// Noise: a normalize word or stray gather outside the usual order.
			if ($urandom_range(0, 4) == 0)
				rand_pixel(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0);
		end
		write_mode(pnm_pkg::MODE_RGBA);
		drive_done = 1'b1;
	end

	initial begin
		wait (drive_done);
		drain();
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

	// Limit: a slow run is about 2000 words on an 8 ns clock, near 1 ms.
	initial begin
		#20_000_000;
		$display("tb_top: done, errors");
		$finish;
	end
endmodule

// ===== sim.f =====
hdl/pnm_pkg.sv
hdl/pnm_if.sv
hdl/pnm_lane.sv
hdl/per_channel_minmax_normalize_core.sv
sim/pnm_tb_if.sv
sim/tb_top.sv
